>>> rtl/nrps_pkg.sv
// ----------------------------------------------------------------------------
// nrps_pkg
// Shared types and constants for the nearest-rectangle search block.
// ----------------------------------------------------------------------------
package nrps_pkg;

  // default table depth
  localparam int MAX_RECTS_DEF = 256;

  // search radius register
  localparam int          RADIUS_W     = 10;
  localparam logic [9:0]  RADIUS_RESET = 10'd250;

  // squared distance widths
  localparam int DIST_W = 20;
  localparam int SUM_W  = 21;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_FOUND = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // one stored rectangle
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] width;
    logic [14:0] height;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  // score of one rectangle leaving the scoring pipeline
  typedef struct packed {
    logic              contained;
    logic              outside;
    logic [SUM_W-1:0]  sq_sum;
    rect_t             rect;
  } score_t;

endpackage

>>> rtl/nrps_ram.sv
// ----------------------------------------------------------------------------
// nrps_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/nrps_score.sv
// ----------------------------------------------------------------------------
// nrps_score
// Three-stage scoring pipeline: edges, clamped offsets, squared distance.
// ----------------------------------------------------------------------------
module nrps_score #(
  parameter int AW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [AW-1:0]          in_idx,
  input  nrps_pkg::rect_t        in_rect,
  input  logic signed [15:0]     px,
  input  logic signed [15:0]     py,
  input  logic [9:0]             radius,
  output logic                   out_valid,
  output logic [AW-1:0]          out_idx,
  output nrps_pkg::score_t       out_res,
  output logic                   active
);

  import nrps_pkg::*;

  // stage 1 registers
  logic               v1;
  logic [AW-1:0]      idx1;
  rect_t              rect1;
  logic signed [17:0] right1;
  logic signed [17:0] bottom1;

  // stage 2 registers
  logic               v2;
  logic [AW-1:0]      idx2;
  rect_t              rect2;
  logic               outside2;
  logic [9:0]         dx2;
  logic [9:0]         dy2;

  // stage 3 registers
  logic               v3;
  logic [AW-1:0]      idx3;
  rect_t              rect3;
  logic               outside3;
  logic               inside3;
  logic [DIST_W-1:0]  sqx3;
  logic [DIST_W-1:0]  sqy3;

  // combinational
  logic signed [17:0] in_left;
  logic signed [17:0] in_top;
  logic signed [17:0] left1;
  logic signed [17:0] top1;
  logic signed [17:0] x18;
  logic signed [17:0] y18;
  logic signed [17:0] r18;
  logic signed [17:0] xmr;
  logic signed [17:0] xpr;
  logic signed [17:0] ymr;
  logic signed [17:0] ypr;
  logic signed [17:0] dxl;
  logic signed [17:0] dxr;
  logic signed [17:0] dyt;
  logic signed [17:0] dyb;
  logic               outside;
  logic [9:0]         dx;
  logic [9:0]         dy;

  // sign-extended coordinates
  assign in_left = {{2{in_rect.left[15]}}, in_rect.left};
  assign in_top  = {{2{in_rect.top[15]}}, in_rect.top};
  assign left1   = {{2{rect1.left[15]}}, rect1.left};
  assign top1    = {{2{rect1.top[15]}}, rect1.top};
  assign x18     = {{2{px[15]}}, px};
  assign y18     = {{2{py[15]}}, py};
  assign r18     = {8'd0, radius};
  assign xmr     = x18 - r18;
  assign xpr     = x18 + r18;
  assign ymr     = y18 - r18;
  assign ypr     = y18 + r18;

  // stage 1: right and bottom edges
  always_ff @(posedge clk) begin
    idx1    <= in_idx;
    rect1   <= in_rect;
    right1  <= in_left + {3'd0, in_rect.width};
    bottom1 <= in_top + {3'd0, in_rect.height};
  end

  // search square test and clamped offsets
  assign dxl     = left1 - x18;
  assign dxr     = x18 - right1;
  assign dyt     = top1 - y18;
  assign dyb     = y18 - bottom1;
  assign outside = (right1 < xmr) || (left1 > xpr) || (bottom1 < ymr) || (top1 > ypr);

  always_comb begin
    dx = '0;
    dy = '0;
    if (x18 < left1) begin
      dx = dxl[9:0];
    end else if (x18 > right1) begin
      dx = dxr[9:0];
    end
    if (y18 < top1) begin
      dy = dyt[9:0];
    end else if (y18 > bottom1) begin
      dy = dyb[9:0];
    end
  end

  // stage 2: offsets within the square fit in the radius width
  always_ff @(posedge clk) begin
    idx2     <= idx1;
    rect2    <= rect1;
    outside2 <= outside;
    dx2      <= dx;
    dy2      <= dy;
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    idx3     <= idx2;
    rect3    <= rect2;
    outside3 <= outside2;
    inside3  <= !outside2 && (dx2 == '0) && (dy2 == '0);
    sqx3     <= dx2 * dx2;
    sqy3     <= dy2 * dy2;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // result
  assign out_valid         = v3;
  assign out_idx           = idx3;
  assign out_res.contained = inside3;
  assign out_res.outside   = outside3;
  assign out_res.sq_sum    = {1'b0, sqx3} + {1'b0, sqy3};
  assign out_res.rect      = rect3;
  assign active            = in_valid || v1 || v2 || v3;

endmodule

>>> rtl/nearest_rect_to_point_search.sv
// ----------------------------------------------------------------------------
// nearest_rect_to_point_search
// Rectangle table in RAM with clear, append and nearest-to-point query.
// ----------------------------------------------------------------------------
// clear, append and unused commands: result in the cycle after acceptance, busy stays low
// query: result once the walk and the scoring pipeline drain, one table read a cycle
//   through the table RAM port; a containing rectangle ends the walk early
// busy stays high for the whole query; the receiver cannot stall results
// reset: table count zero, radius 250, table contents undefined until written
module nearest_rect_to_point_search
  import nrps_pkg::*;
#(
  parameter int MAX_RECTS = MAX_RECTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [14:0]        rect_width,
  input  logic [14:0]        rect_height,
  // radius register
  input  logic               radius_we,
  input  logic [9:0]         radius_wdata,
  // result output
  output logic               done,
  output logic [1:0]         status,
  output logic [7:0]         hit_index,
  output logic signed [15:0] hit_left,
  output logic signed [15:0] hit_top,
  output logic [14:0]        hit_width,
  output logic [14:0]        hit_height,
  output logic               point_inside,
  output logic [19:0]        distance_sq,
  output logic [8:0]         entry_count
);

  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);

  // control state
  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      issue_cnt;
  logic [9:0]         radius;
  logic               rd_v;
  logic [AW-1:0]      rd_idx;
  logic               found_any;
  logic               found_inside;

  // query payload
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic [DIST_W-1:0]  best;
  logic [AW-1:0]      best_idx;
  rect_t              best_rect;

  // combinational
  logic               accept;
  logic               full;
  logic               ram_we;
  logic               rd_req;
  logic               finish;
  logic               issue_end;
  rect_t              wr_rect;
  rect_t              rd_rect;
  logic [RECT_W-1:0]  rd_data;
  logic               sc_valid;
  logic [AW-1:0]      sc_idx;
  score_t             sc_res;
  logic               sc_active;
  logic               take;

  assign accept  = start && !busy;
  assign full    = (count == CW'(MAX_RECTS));
  assign ram_we  = accept && (cmd == CMD_APPEND) && !full;
  assign busy    = (state != S_IDLE);
  assign wr_rect = '{left: pos_x, top: pos_y, width: rect_width, height: rect_height};
  assign rd_rect = rect_t'(rd_data);

  // table memory
  nrps_ram #(
    .WIDTH (RECT_W),
    .DEPTH (MAX_RECTS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_rect),
    .re    (rd_req),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // scoring pipeline
  nrps_score #(
    .AW (AW)
  ) u_score (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .in_idx    (rd_idx),
    .in_rect   (rd_rect),
    .px        (qx),
    .py        (qy),
    .radius    (radius),
    .out_valid (sc_valid),
    .out_idx   (sc_idx),
    .out_res   (sc_res),
    .active    (sc_active)
  );

  // running best: containment wins, else strictly smaller distance
  assign take = sc_valid && !found_inside && !sc_res.outside &&
                (sc_res.contained || (sc_res.sq_sum < {1'b0, best}));

  // walk ends after the last entry or on a containing rectangle
  assign issue_end = found_inside || (issue_cnt == count);

  // next state and scan control
  always_comb begin
    state_next = state;
    rd_req     = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_QUERY)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue_end) begin
          rd_req = 1'b1;
        end else if (!sc_active) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table count after an immediate command
  always_comb begin
    count_next = count;
    if (accept && (cmd == CMD_CLEAR)) begin
      count_next = '0;
    end else if (ram_we) begin
      count_next = count + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      radius       <= RADIUS_RESET;
      rd_v         <= 1'b0;
      found_any    <= 1'b0;
      found_inside <= 1'b0;
      issue_cnt    <= '0;
    end else begin
      count <= count_next;
      rd_v  <= rd_req;
      if (radius_we) begin
        radius <= radius_wdata;
      end
      if (accept && (cmd == CMD_QUERY)) begin
        found_any    <= 1'b0;
        found_inside <= 1'b0;
        issue_cnt    <= '0;
      end else begin
        if (rd_req) begin
          issue_cnt <= issue_cnt + CW'(1);
        end
        if (take) begin
          found_any    <= 1'b1;
          found_inside <= sc_res.contained;
        end
      end
    end
  end

  // query payload registers
  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[AW-1:0];
    if (accept && (cmd == CMD_QUERY)) begin
      qx   <= pos_x;
      qy   <= pos_y;
      best <= radius * radius;
    end else if (take) begin
      best      <= sc_res.contained ? '0 : sc_res.sq_sum[DIST_W-1:0];
      best_idx  <= sc_idx;
      best_rect <= sc_res.rect;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (cmd != CMD_QUERY)) || finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      entry_count <= 9'(count);
      if (found_any) begin
        status       <= ST_FOUND;
        hit_index    <= 8'(best_idx);
        hit_left     <= best_rect.left;
        hit_top      <= best_rect.top;
        hit_width    <= best_rect.width;
        hit_height   <= best_rect.height;
        point_inside <= found_inside;
        distance_sq  <= best;
      end else begin
        status       <= ST_MISS;
        hit_index    <= '0;
        hit_left     <= '0;
        hit_top      <= '0;
        hit_width    <= '0;
        hit_height   <= '0;
        point_inside <= 1'b0;
        distance_sq  <= '0;
      end
    end else if (accept && (cmd != CMD_QUERY)) begin
      entry_count  <= 9'(count_next);
      status       <= ((cmd == CMD_APPEND) && full) ? ST_FULL : ST_DONE;
      hit_index    <= '0;
      hit_left     <= '0;
      hit_top      <= '0;
      hit_width    <= '0;
      hit_height   <= '0;
      point_inside <= 1'b0;
      distance_sq  <= '0;
    end
  end

  // table count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECTS))
    else $error("table count above depth");

  // reads only stored entries, and only during a scan
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_req |-> (busy && (issue_cnt < count)))
    else $error("table read outside stored entries");

  // a query makes the block busy next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_QUERY)) |=> busy)
    else $error("query accepted without scan");

  // a contained point reports zero distance
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && point_inside) |-> ((status == ST_FOUND) && (distance_sq == '0)))
    else $error("inside hit with nonzero distance");

  // table is not written while a scan runs
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ram_we)
    else $error("table write during scan");

endmodule

>>> tb/nearest_rect_to_point_search_tb.sv
// ----------------------------------------------------------------------------
// nearest_rect_to_point_search_tb
// Self-checking bench for the nearest-rectangle search block. Fills the
// rectangle table through append items, runs point queries against it and
// compares every result with a behavioral copy of the search, under several
// search radius settings, the extremes 0 and 1023 included.
// ----------------------------------------------------------------------------
module nearest_rect_to_point_search_tb;
  import nrps_pkg::*;

  // one expected or observed result
  typedef struct packed {
    status_t            outcome;
    logic [7:0]         index;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic               pt_inside;
    logic [19:0]        sq_dist;
    logic [8:0]         count;
  } search_answer_t;

  // table copy, radius copy and queue of pending answers
  class rect_search_scoreboard;
    rect_t          stored_rects[MAX_RECTS_DEF];
    int             stored_total;
    int             radius;
    search_answer_t expected_answers[$];
    int             mismatches;

    function new();
      stored_total = 0;
      radius       = int'(RADIUS_RESET);
      mismatches   = 0;
    endfunction

    function void set_radius(logic [9:0] value);
      radius = int'(value);
    endfunction

    // squared distance to rectangle, radius squared if outside square, -1 inside
    function longint rect_distance(rect_t e, int px, int py);
      int     left, top, right, bottom;
      longint dx, dy;
      left   = $signed(e.left);
      top    = $signed(e.top);
      right  = left + int'(e.width);
      bottom = top + int'(e.height);
      dx = 0;
      dy = 0;
      if (right < px - radius || left > px + radius ||
          bottom < py - radius || top > py + radius)
        return longint'(radius) * radius;
      if (px < left) dx = left - px;
      else if (px > right) dx = px - right;
      if (py < top) dy = top - py;
      else if (py > bottom) dy = py - bottom;
      if (dx == 0 && dy == 0) return -1;
      return dx * dx + dy * dy;
    endfunction

    // apply one accepted item and queue the answer it must produce
    function void record_item(cmd_t op, logic signed [15:0] px, logic signed [15:0] py,
                              logic [14:0] w, logic [14:0] h);
      search_answer_t ans;
      longint         best, limit, s;
      int             best_idx, i;
      rect_t          hit;
      ans = '0;
      case (op)
        CMD_CLEAR: stored_total = 0;
        CMD_APPEND: begin
          if (stored_total >= MAX_RECTS_DEF) begin
            ans.outcome = ST_FULL;
          end else begin
            stored_rects[stored_total] = '{left: px, top: py, width: w, height: h};
            stored_total++;
          end
        end
        CMD_QUERY: begin
          limit    = longint'(radius) * radius;
          best     = limit;
          best_idx = 0;
          for (i = 0; i < stored_total; i++) begin
            s = rect_distance(stored_rects[i], int'(px), int'(py));
            if (s < best) begin
              best     = s;
              best_idx = i;
              if (s < 0) break;
            end
          end
          if (best < limit) begin
            hit           = stored_rects[best_idx];
            ans.outcome   = ST_FOUND;
            ans.index     = 8'(best_idx);
            ans.left      = hit.left;
            ans.top       = hit.top;
            ans.width     = hit.width;
            ans.height    = hit.height;
            ans.pt_inside = (best < 0);
            ans.sq_dist   = (best < 0) ? 20'd0 : 20'(best);
          end else begin
            ans.outcome = ST_MISS;
          end
        end
        default: ;
      endcase
      ans.count = 9'(stored_total);
      expected_answers.push_back(ans);
    endfunction

    function void compare_field(string name, logic signed [20:0] want,
                                logic signed [20:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one observed result with the oldest pending answer
    function void check_result(search_answer_t got);
      search_answer_t want;
      if (expected_answers.size() == 0) begin
        $display("%0t: result with no item pending, expected none, actual status %0d",
                 $time, got.outcome);
        mismatches++;
        return;
      end
      want = expected_answers.pop_front();
      compare_field("status", want.outcome, got.outcome);
      compare_field("hit_index", want.index, got.index);
      compare_field("hit_left", want.left, got.left);
      compare_field("hit_top", want.top, got.top);
      compare_field("hit_width", want.width, got.width);
      compare_field("hit_height", want.height, got.height);
      compare_field("point_inside", want.pt_inside, got.pt_inside);
      compare_field("distance_sq", want.sq_dist, got.sq_dist);
      compare_field("entry_count", want.count, got.count);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        rect_width;
  logic [14:0]        rect_height;
  logic               radius_we;
  logic [9:0]         radius_wdata;
  logic               done;
  logic [1:0]         status;
  logic [7:0]         hit_index;
  logic signed [15:0] hit_left;
  logic signed [15:0] hit_top;
  logic [14:0]        hit_width;
  logic [14:0]        hit_height;
  logic               point_inside;
  logic [19:0]        distance_sq;
  logic [8:0]         entry_count;

  rect_search_scoreboard scoreboard;
  bit                    no_gaps;
  int                    items_sent;

  nearest_rect_to_point_search u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .done         (done),
    .status       (status),
    .hit_index    (hit_index),
    .hit_left     (hit_left),
    .hit_top      (hit_top),
    .hit_width    (hit_width),
    .hit_height   (hit_height),
    .point_inside (point_inside),
    .distance_sq  (distance_sq),
    .entry_count  (entry_count)
  );

  // clock
  always #6 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1)
      scoreboard.check_result('{outcome: status_t'(status), index: hit_index,
                                left: hit_left, top: hit_top, width: hit_width,
                                height: hit_height, pt_inside: point_inside,
                                sq_dist: distance_sq, count: entry_count});
  end

  // run limit
  initial begin
    #36_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // present one item, hold it until accepted; enters and leaves at a falling edge
  task automatic send_item(cmd_t op, logic signed [15:0] px, logic signed [15:0] py,
                           logic [14:0] w, logic [14:0] h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd         = op;
    pos_x       = px;
    pos_y       = py;
    rect_width  = w;
    rect_height = h;
    start       = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    scoreboard.record_item(op, px, py, w, h);
    if (op != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    start = 1'b0;
    while (scoreboard.expected_answers.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  // radius write, only with the block idle
  task automatic write_radius(logic [9:0] value);
    drain_results();
    radius_we    = 1'b1;
    radius_wdata = value;
    @(negedge clk);
    radius_we = 1'b0;
    scoreboard.set_radius(value);
  endtask

  // coordinate near a center, wrapped to 16 bits
  function automatic logic signed [15:0] near(int center, int spread);
    return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // one phase: radius, clear, appends around a center, then queries there
  task automatic run_random_phase(bit fill_table);
    int r, span, cx, cy, n_rects, n_queries, i;
    case ($urandom_range(0, 7))
      0: r = 0;
      1: r = 1;
      2: r = 1023;
      3: r = 250;
      default: r = $urandom_range(1, 1023);
    endcase
    write_radius(10'(r));
    no_gaps   = ($urandom_range(0, 3) == 0);
    span      = (r < 4) ? 8 : r;
    cx        = int'($urandom_range(0, 65535)) - 32768;
    cy        = int'($urandom_range(0, 65535)) - 32768;
    n_rects   = fill_table ? $urandom_range(256, 260) : $urandom_range(1, 24);
    n_queries = $urandom_range(3, 12);
    send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    for (i = 0; i < n_rects; i++) begin
      case ($urandom_range(0, 29))
        0: send_item(CMD_NONE, 16'($urandom), 16'($urandom), 15'($urandom),
                     15'($urandom));
        1: send_item(CMD_APPEND, 16'($urandom), 16'($urandom), 15'($urandom),
                     15'($urandom));
        default: send_item(CMD_APPEND, near(cx - span, 2 * span), near(cy - span, 2 * span),
                           15'($urandom_range(0, 2 * span)),
                           15'($urandom_range(0, 2 * span)));
      endcase
    end
    for (i = 0; i < n_queries; i++) begin
      case ($urandom_range(0, 11))
        0: send_item(CMD_QUERY, 16'($urandom), 16'($urandom), 15'($urandom),
                     15'($urandom));
        1: send_item(CMD_NONE, near(cx, 3 * span), near(cy, 3 * span), 15'($urandom),
                     15'($urandom));
        default: send_item(CMD_QUERY, near(cx, 3 * span), near(cy, 3 * span),
                           15'($urandom), 15'($urandom));
      endcase
    end
  endtask

  // main sequence
  initial begin
    scoreboard   = new();
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = CMD_CLEAR;
    pos_x        = '0;
    pos_y        = '0;
    rect_width   = '0;
    rect_height  = '0;
    radius_we    = 1'b0;
    radius_wdata = '0;
    no_gaps      = 1'b0;
    items_sent   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default radius 250
    send_item(CMD_QUERY, 16'sd0, 16'sd0, 15'd0, 15'd0);
    send_item(CMD_CLEAR, 16'sd0, 16'sd0, 15'd0, 15'd0);
    send_item(CMD_APPEND, -16'sd32768, -16'sd32768, 15'd0, 15'd0);
    send_item(CMD_APPEND, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
    send_item(CMD_APPEND, 16'sd100, 16'sd100, 15'd50, 15'd50);
    send_item(CMD_APPEND, 16'sd100, 16'sd100, 15'd50, 15'd50);
    // inside, on the corner edge, tie with the duplicate entry
    send_item(CMD_QUERY, 16'sd120, 16'sd120, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd150, 16'sd150, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd160, 16'sd100, 15'd0, 15'd0);
    // distance exactly radius squared is rejected, one unit closer in x is accepted
    send_item(CMD_QUERY, 16'sd400, 16'sd120, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd399, 16'sd120, 15'd0, 15'd0);
    // zero size rectangle at the most negative corner
    send_item(CMD_QUERY, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
    send_item(CMD_QUERY, 16'sd32767, -16'sd32768, 15'd0, 15'd0);
    // unused command leaves the table alone
    send_item(CMD_NONE, 16'sd5, 16'sd5, 15'd5, 15'd5);
    send_item(CMD_QUERY, -16'sd200, -16'sd200, 15'd0, 15'd0);
    // zero radius: only containment counts
    write_radius(10'd0);
    send_item(CMD_QUERY, 16'sd125, 16'sd125, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd151, 16'sd125, 15'd0, 15'd0);
    // widest radius, distances near the top of the range
    write_radius(10'd1023);
    send_item(CMD_QUERY, 16'sd1100, 16'sd125, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd873, 16'sd873, 15'd0, 15'd0);
    send_item(CMD_QUERY, 16'sd874, 16'sd873, 15'd0, 15'd0);

    // random phases, the first one sends close to a full table of append items
    run_random_phase(1'b1);
    while (items_sent < 820) run_random_phase($urandom_range(0, 19) == 0);

    drain_results();
    repeat (10) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.expected_answers.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
